/* rtl/core/segment_intersection_unit_defines.svh */
// ----------------------------------------------------------------------------
// segment intersection unit assertion macros
// shared property shorthands for the rtl files that check themselves
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_UNIT_DEFINES_SVH
`define SEGMENT_INTERSECTION_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SIU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SIU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/siu_pkg.sv */
// ----------------------------------------------------------------------------
// siu_pkg
// shared types of the segment intersection unit
// ----------------------------------------------------------------------------
package siu_pkg;

    // control that travels beside each pipeline word
    typedef struct packed {
        logic valid;
        logic hit;
    } ctl_t;

endpackage

/* rtl/core/seg_in_if.sv */
// ----------------------------------------------------------------------------
// seg_in_if
// input channel: two segments, valid/ready handshake
// ----------------------------------------------------------------------------
interface seg_in_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic signed [W-1:0] a_start_x;
    logic signed [W-1:0] a_start_y;
    logic signed [W-1:0] a_end_x;
    logic signed [W-1:0] a_end_y;
    logic signed [W-1:0] b_start_x;
    logic signed [W-1:0] b_start_y;
    logic signed [W-1:0] b_end_x;
    logic signed [W-1:0] b_end_y;

    modport source (
        output valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        input  ready
    );
    modport sink (
        input  valid, a_start_x, a_start_y, a_end_x, a_end_y,
               b_start_x, b_start_y, b_end_x, b_end_y,
        output ready
    );
endinterface

// ----------------------------------------------------------------------------
// seg_out_if
// result channel: hit flag and crossing point, valid/ready handshake
// ----------------------------------------------------------------------------
interface seg_out_if #(
    parameter int W = 16
);
    logic                valid;
    logic                ready;
    logic                hit;
    logic signed [W-1:0] cross_x;
    logic signed [W-1:0] cross_y;

    modport source (
        output valid, hit, cross_x, cross_y,
        input  ready
    );
    modport sink (
        input  valid, hit, cross_x, cross_y,
        output ready
    );
endinterface

/* rtl/core/segment_intersection_unit.sv */
// ----------------------------------------------------------------------------
// segment_intersection_unit
// 2-d segment intersection test, fixed point, fully pipelined
// ----------------------------------------------------------------------------
//  channel   dir   handshake     word
//  seg_in    in    valid/ready   two segments, eight signed coordinates
//  seg_out   out   valid/ready   hit flag and crossing point
//
//  a word enters every cycle while seg_out keeps taking results; the stage count
//  is COORD-independent (deltas, products, cross terms, tests, T_FRAC_BITS + 1
//  divider stages, scale multiply, output add); one bit per divider stage sets it
//  each stage advances when its successor is free, so bubbles close up and a
//  stall on seg_out holds every word in place without loss or repeat
//  reset clears only the stage valid bits and the divider control words; no other state
// ----------------------------------------------------------------------------
`include "segment_intersection_unit_defines.svh"

module segment_intersection_unit #(
    parameter int COORD_WIDTH = 16,
    parameter int T_FRAC_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    seg_in_if.sink    seg_in,
    seg_out_if.source seg_out
);
    localparam int CW  = COORD_WIDTH;
    localparam int DW  = CW + 1;          // delta width
    localparam int PRW = 2 * DW;          // product width
    localparam int PW  = PRW + 1;         // cross term width
    localparam int MW  = T_FRAC_BITS + 2 + DW; // scale product width
    localparam int SW  = 2 * CW + 2 * DW;     // sideband into divider

    // stage 1: deltas and offset
    logic                  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic                  r1, r2, r3, r4, r5, r6;
    logic signed [CW-1:0]  ax1_reg, ay1_reg;
    logic signed [DW-1:0]  dax1_reg, day1_reg, dbx1_reg, dby1_reg, ox1_reg, oy1_reg;

    // stage 2: products
    logic signed [CW-1:0]  ax2_reg, ay2_reg;
    logic signed [DW-1:0]  dax2_reg, day2_reg;
    logic signed [PRW-1:0] p_ab_reg, p_ba_reg, p_sa_reg, p_sb_reg, p_ta_reg, p_tb_reg;

    // stage 3: cross terms
    logic signed [CW-1:0]  ax3_reg, ay3_reg;
    logic signed [DW-1:0]  dax3_reg, day3_reg;
    logic signed [PW-1:0]  den_reg, sn_reg, tn_reg;

    // stage 4: hit test and magnitudes
    logic signed [CW-1:0]  ax4_reg, ay4_reg;
    logic signed [DW-1:0]  dax4_reg, day4_reg;
    logic                  hit4_reg;
    logic [PW-1:0]         tmag_reg, dmag_reg;
    logic                  hit_next;
    logic                  den_nz, pos;

    // divider handoff
    siu_pkg::ctl_t         div_in_ctl, div_out_ctl;
    logic                  div_in_ready;
    logic [T_FRAC_BITS:0]  tq;
    logic [SW-1:0]         div_side;
    logic signed [CW-1:0]  axd, ayd;
    logic signed [DW-1:0]  daxd, dayd;

    // stage 5: scale products
    logic signed [CW-1:0]  ax5_reg, ay5_reg;
    logic signed [MW-1:0]  mx_reg, my_reg;
    logic                  hit5_reg;

    // stage 6: output word
    logic                  hit6_reg;
    logic signed [CW-1:0]  cx_reg, cy_reg;
    logic signed [MW-1:0]  shx, shy;

    // ready chain, back to front
    assign r6 = !v6_reg || seg_out.ready;
    assign r5 = !v5_reg || r6;
    assign r4 = !v4_reg || div_in_ready;
    assign r3 = !v3_reg || r4;
    assign r2 = !v2_reg || r3;
    assign r1 = !v1_reg || r2;
    assign seg_in.ready = r1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (r1) v1_reg <= seg_in.valid;
            if (r2) v2_reg <= v1_reg;
            if (r3) v3_reg <= v2_reg;
            if (r4) v4_reg <= v3_reg;
            if (r5) v5_reg <= div_out_ctl.valid;
            if (r6) v6_reg <= v5_reg;
        end
    end

    // stage 1
    always_ff @(posedge clk)
    begin
        if (r1)
        begin
            ax1_reg  <= seg_in.a_start_x;
            ay1_reg  <= seg_in.a_start_y;
            dax1_reg <= DW'(seg_in.a_end_x) - DW'(seg_in.a_start_x);
            day1_reg <= DW'(seg_in.a_end_y) - DW'(seg_in.a_start_y);
            dbx1_reg <= DW'(seg_in.b_end_x) - DW'(seg_in.b_start_x);
            dby1_reg <= DW'(seg_in.b_end_y) - DW'(seg_in.b_start_y);
            ox1_reg  <= DW'(seg_in.a_start_x) - DW'(seg_in.b_start_x);
            oy1_reg  <= DW'(seg_in.a_start_y) - DW'(seg_in.b_start_y);
        end
    end

    // stage 2: six narrow multiplies in parallel
    always_ff @(posedge clk)
    begin
        if (r2)
        begin
            ax2_reg  <= ax1_reg;
            ay2_reg  <= ay1_reg;
            dax2_reg <= dax1_reg;
            day2_reg <= day1_reg;
            p_ab_reg <= dax1_reg * dby1_reg;
            p_ba_reg <= dbx1_reg * day1_reg;
            p_sa_reg <= dax1_reg * oy1_reg;
            p_sb_reg <= day1_reg * ox1_reg;
            p_ta_reg <= dbx1_reg * oy1_reg;
            p_tb_reg <= dby1_reg * ox1_reg;
        end
    end

    // stage 3: denominator and numerators
    always_ff @(posedge clk)
    begin
        if (r3)
        begin
            ax3_reg  <= ax2_reg;
            ay3_reg  <= ay2_reg;
            dax3_reg <= dax2_reg;
            day3_reg <= day2_reg;
            den_reg  <= PW'(p_ab_reg) - PW'(p_ba_reg);
            sn_reg   <= PW'(p_sa_reg) - PW'(p_sb_reg);
            tn_reg   <= PW'(p_ta_reg) - PW'(p_tb_reg);
        end
    end

    // stage 4: parallel/sign/range tests, magnitudes for the divider
    assign den_nz = (den_reg != '0);
    assign pos    = den_nz && !den_reg[PW-1];

    always_comb
    begin
        hit_next = den_nz
                && (sn_reg[PW-1] != pos) && (tn_reg[PW-1] != pos)
                && ((sn_reg > den_reg) != pos) && ((tn_reg > den_reg) != pos);
    end

    always_ff @(posedge clk)
    begin
        if (r4)
        begin
            ax4_reg  <= ax3_reg;
            ay4_reg  <= ay3_reg;
            dax4_reg <= dax3_reg;
            day4_reg <= day3_reg;
            hit4_reg <= hit_next;
            tmag_reg <= tn_reg[PW-1] ? PW'(-tn_reg) : PW'(tn_reg);
            dmag_reg <= den_reg[PW-1] ? PW'(-den_reg) : PW'(den_reg);
        end
    end

    assign div_in_ctl.valid = v4_reg;
    assign div_in_ctl.hit   = hit4_reg;

    siu_frac_div #(
        .NW     (PW),
        .FRAC   (T_FRAC_BITS),
        .SIDE_W (SW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ctl    (div_in_ctl),
        .in_ready  (div_in_ready),
        .num       (tmag_reg),
        .den       (dmag_reg),
        .in_side   ({ax4_reg, ay4_reg, dax4_reg, day4_reg}),
        .out_ctl   (div_out_ctl),
        .out_ready (r5),
        .quo       (tq),
        .out_side  (div_side)
    );

    assign {axd, ayd, daxd, dayd} = div_side;

    // stage 5: t times delta, t is unsigned
    always_ff @(posedge clk)
    begin
        if (r5)
        begin
            ax5_reg  <= axd;
            ay5_reg  <= ayd;
            hit5_reg <= div_out_ctl.hit;
            mx_reg   <= MW'($signed({1'b0, tq})) * MW'(daxd);
            my_reg   <= MW'($signed({1'b0, tq})) * MW'(dayd);
        end
    end

    // stage 6: floor shift, add start, zero on no hit
    assign shx = mx_reg >>> T_FRAC_BITS;
    assign shy = my_reg >>> T_FRAC_BITS;

    always_ff @(posedge clk)
    begin
        if (r6)
        begin
            hit6_reg <= hit5_reg;
            cx_reg   <= hit5_reg ? (ax5_reg + CW'(shx)) : '0;
            cy_reg   <= hit5_reg ? (ay5_reg + CW'(shy)) : '0;
        end
    end

    assign seg_out.valid   = v6_reg;
    assign seg_out.hit     = hit6_reg;
    assign seg_out.cross_x = cx_reg;
    assign seg_out.cross_y = cy_reg;

    // checks
    `SIU_ASSERT_NOW(a_miss_zero, seg_out.valid && !seg_out.hit,
        (seg_out.cross_x == '0) && (seg_out.cross_y == '0), "miss with nonzero point")
    `SIU_ASSERT_NOW(a_t_bound, div_out_ctl.valid && div_out_ctl.hit,
        tq <= (T_FRAC_BITS+1)'(1) << T_FRAC_BITS, "fraction above one")
    `SIU_ASSERT_NEXT(a_hit_den, r4 && v3_reg && (den_reg == '0),
        !hit4_reg, "hit on zero denominator")
    `SIU_ASSERT_NOW(a_drain_ready, !v1_reg && !v2_reg && !v3_reg,
        seg_in.ready, "input blocked with empty front")

endmodule

/* rtl/core/siu_frac_div.sv */
// ----------------------------------------------------------------------------
// siu_frac_div
// pipelined restoring divider, floor(num * 2^FRAC / den), one bit per stage
// ----------------------------------------------------------------------------
module siu_frac_div #(
    parameter int NW     = 35,
    parameter int FRAC   = 16,
    parameter int SIDE_W = 66
) (
    input  logic                clk,
    input  logic                rst_n,
    input  siu_pkg::ctl_t       in_ctl,
    output logic                in_ready,
    input  logic [NW-1:0]       num,
    input  logic [NW-1:0]       den,
    input  logic [SIDE_W-1:0]   in_side,
    output siu_pkg::ctl_t       out_ctl,
    input  logic                out_ready,
    output logic [FRAC:0]       quo,
    output logic [SIDE_W-1:0]   out_side
);
    localparam int NST = FRAC + 1;

    siu_pkg::ctl_t     ctl_reg  [NST];
    logic [NW-1:0]     rem_reg  [NST];
    logic [NW-1:0]     den_reg  [NST];
    logic [FRAC:0]     q_reg    [NST];
    logic [SIDE_W-1:0] side_reg [NST];
    logic [NST:0]      rdy;

    assign rdy[NST] = out_ready;

    genvar k;
    generate
        for (k = 0; k < NST; k++) begin : g_stage
            assign rdy[k] = !ctl_reg[k].valid || rdy[k+1];

            if (k == 0) begin : g_first
                logic ge;
                assign ge = (num >= den);

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        ctl_reg[k] <= '0;
                    else if (rdy[k])
                        ctl_reg[k] <= in_ctl;
                end

                always_ff @(posedge clk)
                begin
                    if (rdy[k])
                    begin
                        rem_reg[k]  <= ge ? (num - den) : num;
                        den_reg[k]  <= den;
                        q_reg[k]    <= {{FRAC{1'b0}}, ge};
                        side_reg[k] <= in_side;
                    end
                end
            end else begin : g_next
                logic [NW:0] sh;
                logic [NW:0] dn;
                logic        ge;
                assign sh = {rem_reg[k-1], 1'b0};
                assign dn = {1'b0, den_reg[k-1]};
                assign ge = (sh >= dn);

                always_ff @(posedge clk or negedge rst_n)
                begin
                    if (!rst_n)
                        ctl_reg[k] <= '0;
                    else if (rdy[k])
                        ctl_reg[k] <= ctl_reg[k-1];
                end

                always_ff @(posedge clk)
                begin
                    if (rdy[k])
                    begin
                        rem_reg[k]  <= ge ? NW'(sh - dn) : NW'(sh);
                        den_reg[k]  <= den_reg[k-1];
                        q_reg[k]    <= {q_reg[k-1][FRAC-1:0], ge};
                        side_reg[k] <= side_reg[k-1];
                    end
                end
            end
        end
    endgenerate

    assign in_ready = rdy[0];
    assign out_ctl  = ctl_reg[NST-1];
    assign quo      = q_reg[NST-1];
    assign out_side = side_reg[NST-1];

endmodule
